// File: src/assert_macros.svh
// Assertion macros shared by the neighbor table RTL.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: src/ntt_pkg.sv
// Package for the neighbor table: sizes, status codes and item types.
// No dependencies.
`timescale 1ns / 1ps
package ntt_pkg;
  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_REUSED = 3'd1;
  localparam logic [2:0] ST_APPENDED = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_TICK = 3'd4;

  localparam logic [0:0] REG_TTL_RELOAD = 1'b0;

  typedef struct packed {
    logic        tick;
    logic [63:0] vehicle_id;
    logic [7:0]  safe_flag;
    logic [15:0] stored_distance;
    logic [15:0] altitude;
    logic [11:0] speed_kmh;
    logic [15:0] heading;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [5:0]  used_count;
    logic [15:0] stored_distance;
    logic [11:0] speed_kmh;
  } res_t;
endpackage

// File: src/neighbor_table_with_ttl.sv
// Top level of the neighbor table with TTL aging.
// Depends on ntt_pkg, ntt_front and ntt_back.
`timescale 1ns / 1ps
// Input words carry vehicle reports (tuser = 0) or aging ticks (tuser = 1).
// Each input word gives exactly one output word with status, slot, used count,
// stored distance and speed in km/h. Reports search the table one entry at a
// time, passing through a scan and a compare state for each entry, and a tick
// steps through the used entries once; the sequential scan through the ID
// memory sets the time from input to result.
// The front end converts distance and speed and queues two words, so input
// is accepted while the back end works or while a result waits.
// A stalled receiver holds the result register and the back end stops; the
// queue then fills and in_tready drops.
// Reset clears all TTLs, the used count and sets ttl_reload to 10; no clearing
// pass is needed. ttl_reload is written over the APB port at address 0; the user
// must write it only while the block is idle, which the block does not enforce.
module neighbor_table_with_ttl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vehicle_id, safe_flag, raw_distance, vehicle_length, altitude, speed_cms,
  // heading, from the lowest bit up
  input  logic [143:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot, used_count, stored_distance, speed_kmh, zero fill
  output logic [39:0]  out_tdata,
  // status
  output logic [2:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import ntt_pkg::*;

  logic [7:0] ttl_reload_r;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TTL_RELOAD) ? {24'd0, ttl_reload_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_reload_r <= 8'd10;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_TTL_RELOAD
                 && cfg_paddr[1:0] == 2'd0) begin
      ttl_reload_r <= cfg_pwdata[7:0];
    end
  end

  ntt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .mode(in_tuser), .vehicle_id(in_tdata[63:0]), .safe_flag(in_tdata[71:64]),
    .raw_distance(in_tdata[87:72]), .vehicle_length(in_tdata[95:88]),
    .altitude(in_tdata[111:96]), .speed_cms(in_tdata[127:112]),
    .heading(in_tdata[143:128]), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd)
  );

  ntt_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .ttl_reload(ttl_reload_r), .res_valid(out_tvalid),
    .res_ready(out_tready), .res(res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {1'b0, res.speed_kmh, res.stored_distance, res.used_count, res.slot};
endmodule

// File: src/ntt_front.sv
// Front end: takes input words, computes distance and speed, queues commands.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
module ntt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [63:0]         vehicle_id,
  input  logic [7:0]          safe_flag,
  input  logic [15:0]         raw_distance,
  input  logic [7:0]          vehicle_length,
  input  logic [15:0]         altitude,
  input  logic [15:0]         speed_cms,
  input  logic [15:0]         heading,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ntt_pkg::cmd_t       cmd
);
  import ntt_pkg::*;
  `include "assert_macros.svh"

  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  cmd_t c;
  logic [6:0] half;
  logic [43:0] prod;
  logic push, pop;

  // Speed in km/h is speed_cms * 36 / 1000, taken as a multiply by the scaled
  // reciprocal 36 * 2^32 / 1000 rounded up, then a shift by 32.
  always_comb begin
    half = vehicle_length[7:1];
    prod = {28'd0, speed_cms} * 44'd154618823;
    c.tick = mode;
    c.vehicle_id = vehicle_id;
    c.safe_flag = safe_flag;
    c.stored_distance = (raw_distance > {9'd0, half}) ?
                        raw_distance - {9'd0, half} : raw_distance;
    c.altitude = altitude;
    c.speed_kmh = prod[43:32];
    c.heading = heading;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_CLK(a_q_bound, clk, rst_n, cnt_r <= 2'd2, "queue count out of range")
  `ASSERT_CLK(a_q_ptr, clk, rst_n, (cnt_r == 2'd1) |-> (wp_r != rp_r), "queue pointers")
endmodule

// File: src/ntt_back.sv
// Back end: sequential table search, update and aging, result register.
// Depends on ntt_pkg.
`timescale 1ns / 1ps
module ntt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ntt_pkg::cmd_t cmd,
  input  logic [7:0]    ttl_reload,
  output logic          res_valid,
  input  logic          res_ready,
  output ntt_pkg::res_t res
);
  import ntt_pkg::*;
  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CMP = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_TICK = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [63:0] id_mem [ENTRIES];
  logic [7:0]  safe_mem [ENTRIES];
  logic [15:0] dist_mem [ENTRIES];
  logic [15:0] alt_mem [ENTRIES];
  logic [11:0] spd_mem [ENTRIES];
  logic [15:0] hdg_mem [ENTRIES];
  logic [7:0]  ttl_r [ENTRIES];

  logic [2:0] st_r;
  cmd_t cmd_r;
  logic [CNT_W-1:0] used_r, idx_r;
  logic [63:0] rd_id_r;
  logic [IDX_W-1:0] slot_r, dead_r;
  logic dead_found_r, hit_r;
  res_t work_r;
  res_t res_r;
  logic res_valid_r;
  logic [IDX_W-1:0] idx;

  assign idx = idx_r[IDX_W-1:0];
  assign cmd_ready = (st_r == S_IDLE);
  assign res_valid = res_valid_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    rd_id_r <= id_mem[idx];
    if (st_r == S_WRITE && hit_r) begin
      id_mem[slot_r] <= cmd_r.vehicle_id;
      safe_mem[slot_r] <= cmd_r.safe_flag;
      dist_mem[slot_r] <= cmd_r.stored_distance;
      alt_mem[slot_r] <= cmd_r.altitude;
      spd_mem[slot_r] <= cmd_r.speed_kmh;
      hdg_mem[slot_r] <= cmd_r.heading;
    end
    if (st_r == S_IDLE && cmd_valid) cmd_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      used_r <= '0;
      idx_r <= '0;
      res_valid_r <= 1'b0;
      hit_r <= 1'b0;
      dead_found_r <= 1'b0;
      slot_r <= '0;
      dead_r <= '0;
      work_r <= '0;
      res_r <= '0;
      for (int i = 0; i < ENTRIES; i++) ttl_r[i] <= 8'd0;
    end else begin
      if (st_r == S_OUT && (!res_valid_r || res_ready)) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            idx_r <= '0;
            hit_r <= 1'b0;
            dead_found_r <= 1'b0;
            st_r <= cmd.tick ? S_TICK : S_SCAN;
          end
        end
        S_TICK: begin
          if (idx_r < used_r) begin
            if (ttl_r[idx] != 8'd0) ttl_r[idx] <= ttl_r[idx] - 8'd1;
            idx_r <= idx_r + 1'b1;
          end else begin
            work_r <= '{ST_TICK, 5'd0, 6'(used_r), 16'd0, 12'd0};
            st_r <= S_OUT;
          end
        end
        S_SCAN: begin
          if (idx_r < used_r) begin
            st_r <= S_CMP;
          end else if (dead_found_r) begin
            slot_r <= dead_r;
            hit_r <= 1'b1;
            work_r.status <= ST_REUSED;
            st_r <= S_WRITE;
          end else if (used_r < CNT_W'(ENTRIES)) begin
            slot_r <= used_r[IDX_W-1:0];
            used_r <= used_r + 1'b1;
            hit_r <= 1'b1;
            work_r.status <= ST_APPENDED;
            st_r <= S_WRITE;
          end else begin
            work_r <= '{ST_FULL, 5'd0, 6'(used_r), 16'd0, 12'd0};
            st_r <= S_OUT;
          end
        end
        S_CMP: begin
          if (rd_id_r == cmd_r.vehicle_id) begin
            slot_r <= idx;
            hit_r <= 1'b1;
            work_r.status <= ST_UPDATED;
            st_r <= S_WRITE;
          end else begin
            if (!dead_found_r && ttl_r[idx] == 8'd0) begin
              dead_found_r <= 1'b1;
              dead_r <= idx;
            end
            idx_r <= idx_r + 1'b1;
            st_r <= S_SCAN;
          end
        end
        S_WRITE: begin
          ttl_r[slot_r] <= ttl_reload;
          work_r.slot <= 5'(slot_r);
          work_r.used_count <= 6'(used_r);
          work_r.stored_distance <= cmd_r.stored_distance;
          work_r.speed_kmh <= cmd_r.speed_kmh;
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid_r || res_ready) begin
            res_r <= work_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_used_max, clk, rst_n, used_r <= CNT_W'(ENTRIES), "used count overflow")
  `ASSERT_CLK(a_used_mono, clk, rst_n, used_r >= $past(used_r), "used count shrank")
  `ASSERT_CLK(a_write_hit, clk, rst_n, (st_r == S_WRITE) |-> hit_r, "write without slot")
endmodule

// File: tb/tb_neighbor_table_with_ttl.sv
// Self-checking testbench for neighbor_table_with_ttl: drives reports and aging
// ticks, predicts each result word with its own table model and compares fields.
// Depends on ntt_pkg and the neighbor_table_with_ttl RTL.
`timescale 1ns / 1ps
module tb_neighbor_table_with_ttl;
  import ntt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [5:0]  used_count;
    logic [15:0] stored_distance;
    logic [11:0] speed_kmh;
  } nbr_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [143:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  neighbor_table_with_ttl dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted table state.
  logic [63:0] tbl_id [ENTRIES];
  logic [7:0]  tbl_ttl [ENTRIES];
  int          tbl_used;
  logic [7:0]  reload_val;

  nbr_result_t pending_results [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  bit  hold_off = 1'b0;
  logic [63:0] id_pool [$];

  function automatic nbr_result_t predict_table(input bit tick, input logic [63:0] vid,
      input logic [15:0] raw_dist, input logic [7:0] vlen, input logic [15:0] spd);
    nbr_result_t r;
    int hit;
    logic [15:0] half;
    r = '{default: '0};
    if (tick) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (tbl_ttl[i] != 0) tbl_ttl[i]--;
      end
      r.status = ST_TICK;
      r.used_count = tbl_used[5:0];
      return r;
    end
    hit = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_id[i] == vid) hit = i;
    end
    r.status = ST_UPDATED;
    if (hit < 0) begin
      for (int i = 0; i < tbl_used; i++) begin
        if (hit < 0 && tbl_ttl[i] == 0) hit = i;
      end
      if (hit >= 0) begin
        r.status = ST_REUSED;
      end else if (tbl_used < ENTRIES) begin
        hit = tbl_used;
        tbl_used++;
        r.status = ST_APPENDED;
      end else begin
        r.status = ST_FULL;
        r.used_count = tbl_used[5:0];
        return r;
      end
    end
    half = {9'd0, vlen[7:1]};
    r.stored_distance = (raw_dist > half) ? raw_dist - half : raw_dist;
    r.speed_kmh = 12'((32'(spd) * 36) / 1000);
    tbl_id[hit] = vid;
    tbl_ttl[hit] = reload_val;
    r.slot = hit[4:0];
    r.used_count = tbl_used[5:0];
    return r;
  endfunction

  task automatic send_word(input bit tick, input logic [63:0] vid, input logic [7:0] safe,
      input logic [15:0] raw_dist, input logic [7:0] vlen, input logic [15:0] alt,
      input logic [15:0] spd, input logic [15:0] hdg);
    repeat (send_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= tick;
    in_tdata <= {hdg, spd, alt, vlen, raw_dist, safe, vid};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_table(tick, vid, raw_dist, vlen, spd));
    send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) send_gap = 0;
    if (send_gap != 0) in_tvalid <= 1'b0;
  endtask

  task automatic send_report(input logic [63:0] vid, input logic [15:0] raw_dist,
      input logic [7:0] vlen, input logic [15:0] spd);
    send_word(1'b0, vid, 8'($urandom), raw_dist, vlen, 16'($urandom), spd, 16'($urandom));
  endtask

  task automatic send_tick();
    send_word(1'b1, {$urandom, $urandom}, 8'($urandom), 16'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 20) @(posedge clk);
  endtask

  task automatic write_reload(input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 3'(REG_TTL_RELOAD) << 2;
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    reload_val = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic test_field_extremes();
    send_report(64'd0, 16'd0, 8'd0, 16'd0);
    send_report('1, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_report(64'h0123_4567_89AB_CDEF, 16'd3, 8'd7, 16'd27);
    send_report(64'h0123_4567_89AB_CDEF, 16'd4, 8'd9, 16'd28);
    send_word(1'b0, 64'hAAAA_5555_AAAA_5555, 8'hFF, 16'h8000, 8'd2, 16'h8000,
              16'd1000, 16'h7FFF);
    send_word(1'b0, 64'h5555_AAAA_5555_AAAA, 8'h00, 16'd1, 8'd255, 16'h7FFF,
              16'd999, 16'h8000);
    send_tick();
  endtask

  task automatic test_dead_entries();
    write_reload(8'd1);
    send_report(64'd77, 16'd50, 8'd4, 16'd500);
    send_report(64'd78, 16'd60, 8'd4, 16'd500);
    send_tick();
    send_report(64'd77, 16'd70, 8'd4, 16'd500);
    send_report(64'd99, 16'd80, 8'd4, 16'd500);
    send_tick();
    wait_drained();
    write_reload(8'd0);
    send_report(64'd555, 16'd10, 8'd0, 16'd10);
    send_report(64'd556, 16'd10, 8'd0, 16'd10);
    wait_drained();
  endtask

  task automatic test_table_full();
    write_reload(8'd255);
    while (tbl_used < ENTRIES) send_report({$urandom, $urandom}, 16'($urandom), 8'($urandom),
                                           16'($urandom));
    send_report({$urandom, $urandom}, 16'd5, 8'd5, 16'd5);
    send_report(tbl_id[3], 16'd5, 8'd5, 16'd5);
    send_tick();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_report(pick_id(), 16'($urandom), 8'($urandom),
                                            16'($urandom));
    send_tick();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [7:0] reloads [5];
    reloads = '{8'd1, 8'd3, 8'd255, 8'd0, 8'd10};
    for (int ph = 0; ph < 5; ph++) begin
      wait_drained();
      write_reload(reloads[ph]);
      id_pool.delete();
      for (int i = 0; i < 12; i++) id_pool.push_back({$urandom, $urandom});
      for (int n = 0; n < 330; n++) begin
        if ($urandom_range(0, 4) == 0) send_tick();
        else send_report(pick_id(), 16'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_off = 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_tready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end
  end

  always @(posedge clk) begin
    nbr_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word status=%0d", out_tuser);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser != exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
          error_count++;
        end
        if (out_tdata[4:0] != exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, out_tdata[4:0]);
          error_count++;
        end
        if (out_tdata[10:5] != exp_r.used_count) begin
          $error("used_count: expected %0d, got %0d", exp_r.used_count, out_tdata[10:5]);
          error_count++;
        end
        if (out_tdata[26:11] != exp_r.stored_distance) begin
          $error("stored_distance: expected %0d, got %0d", exp_r.stored_distance,
                 out_tdata[26:11]);
          error_count++;
        end
        if (out_tdata[38:27] != exp_r.speed_kmh) begin
          $error("speed_kmh: expected %0d, got %0d", exp_r.speed_kmh, out_tdata[38:27]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("neighbor_table_with_ttl regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_id[i] = '0;
      tbl_ttl[i] = '0;
    end
    tbl_used = 0;
    reload_val = 8'd10;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    wait_drained();
    test_dead_entries();
    test_backpressure();
    test_table_full();
    test_random_traffic();
    wait_drained();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("neighbor_table_with_ttl regression: pass");
    end else begin
      $display("neighbor_table_with_ttl regression: fail");
    end
    $finish;
  end
endmodule
